@@ sv/pwpr_pkg.sv @@
`default_nettype none
package pwpr_pkg;
	typedef enum logic [3:0] {
		EV_NONE = 4'd0, EV_INTERESTED = 4'd1, EV_INT_REQ = 4'd2, EV_UNCHOKED = 4'd3,
		EV_KEEPALIVE = 4'd4, EV_HAVE_SET = 4'd5, EV_BITFIELD = 4'd6, EV_BLOCK = 4'd7,
		EV_COMPLETE = 4'd8, EV_WRONG_PIECE = 4'd9, EV_CHOKED = 4'd10, EV_SHORT = 4'd11,
		EV_OVERFLOW = 4'd12, EV_HAVE_RANGE = 4'd13
	} event_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0, PH_WAIT = 3'd1, PH_LOAD = 3'd2, PH_DONE = 3'd3, PH_FAIL = 3'd4
	} phase_t;

	localparam logic [7:0] KIND_CHOKE    = 8'd0;
	localparam logic [7:0] KIND_UNCHOKE  = 8'd1;
	localparam logic [7:0] KIND_HAVE     = 8'd4;
	localparam logic [7:0] KIND_BITFIELD = 8'd5;
	localparam logic [7:0] KIND_PIECE    = 8'd7;
	localparam logic [31:0] PIECE_MIN = 32'd9;
	localparam logic [31:0] PIECE_HDR = 32'd8;
	localparam logic [31:0] HAVE_LEN  = 32'd4;

	localparam int BLOCK_BYTES = 16384;
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int MAX_BLOCKS  = 1024;

	localparam logic [1:0] CFG_PIECE_NUMBER = 2'd0;
	localparam logic [1:0] CFG_PIECE_BYTES  = 2'd1;
	localparam logic [1:0] CFG_MAP_BYTES    = 2'd2;

	typedef struct packed {
		logic        action;
		logic [7:0]  rx_byte;
	} in_word_t;

	typedef struct packed {
		logic        data_valid;
		logic [23:0] data_offset;
		logic [7:0]  data_byte;
		logic [3:0]  event_res;
		logic [10:0] block_count;
		logic [10:0] blocks_done;
		logic [2:0]  phase;
	} out_word_t;
endpackage
`default_nettype wire

@@ sv/pwpr_if.sv @@
`default_nettype none
interface pwpr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;
	modport source (output valid, action, rx_byte, input ready);
	modport sink (input valid, action, rx_byte, output ready);
endinterface

interface pwpr_out_if;
	logic        valid;
	logic        ready;
	logic        data_valid;
	logic [23:0] data_offset;
	logic [7:0]  data_byte;
	logic [3:0]  event_res;
	logic [10:0] block_count;
	logic [10:0] blocks_done;
	logic [2:0]  phase;
	modport source (output valid, data_valid, data_offset, data_byte, event_res,
		block_count, blocks_done, phase, input ready);
	modport sink (input valid, data_valid, data_offset, data_byte, event_res,
		block_count, blocks_done, phase, output ready);
endinterface

interface pwpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/pwpr_queue.sv @@
`default_nettype none
module pwpr_queue
	import pwpr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	input  wire in_word_t wr_data,
	output logic          rd_valid,
	input  wire logic     rd_ready,
	output in_word_t      rd_data
);
	in_word_t   mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count overflow");
	a_nopop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> !pop) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd4 && !pop) |=> cnt_q == 3'd4) else $error("full queue lost word");
endmodule
`default_nettype wire

@@ sv/pwpr_engine.sv @@
`default_nettype none
module pwpr_engine
	import pwpr_pkg::*;
#(
	parameter int PIECE_SLOTS = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_word_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_word_t        out_data,
	input  wire logic [31:0] piece_number,
	input  wire logic [24:0] piece_bytes,
	input  wire logic [10:0] have_map_bytes
);
	localparam int MAP_BYTES = (PIECE_SLOTS + 7) / 8;
	localparam int MAW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	logic [2:0]  pc_q;
	logic [31:0] mlen_q;
	logic [7:0]  kind_q;
	logic [31:0] pos_q;
	logic [31:0] hdr_q;
	logic        drop_q;
	phase_t      ph_q;
	logic        choke_q;
	logic [10:0] acc_q;
	logic [7:0]  map_q [MAP_BYTES];
	logic        clr_q;
	logic [MAW-1:0] cidx_q;
	out_word_t   out_q;
	logic        ov_q;

	logic        take;
	logic [2:0]  pc_n;
	logic [31:0] mlen_n, pos_n, hdr_n, plen, hdr_sh, dlen;
	logic [7:0]  kind_n, b;
	logic        drop_n, choke_n;
	phase_t      ph_n;
	logic [10:0] acc_n;
	event_t      ev;
	logic        dv, last;
	logic [23:0] doff;
	logic        mwe;
	logic [MAW-1:0] midx;
	logic [7:0]  mdata;
	logic [7:0]  mold;
	logic [25:0] bn_raw;
	logic [10:0] bneed;
	logic [32:0] ovs;
	logic [34:0] hlim;
	logic [7:0]  pmask, wmask;
	logic [31:0] pbase;

	assign bn_raw = (26'(piece_bytes) + 26'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
	assign bneed = (bn_raw > 26'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : bn_raw[10:0];

	assign in_ready = !clr_q && (!ov_q || out_ready);
	assign take = in_valid && in_ready;
	assign b = in_data.rx_byte;
	assign plen = mlen_q - 32'd1;
	assign last = (pos_q + 32'd1) == plen;
	assign hdr_sh = {hdr_q[23:0], b};
	assign dlen = plen - PIECE_HDR;
	assign ovs = {1'b0, hdr_sh} + {1'b0, dlen};
	assign hlim = {24'd0, have_map_bytes} << 3;
	assign mold = 8'd0;

	always_comb begin
		pc_n = pc_q; mlen_n = mlen_q; kind_n = kind_q; pos_n = pos_q; hdr_n = hdr_q;
		drop_n = drop_q; ph_n = ph_q; choke_n = choke_q; acc_n = acc_q;
		ev = EV_NONE; dv = 1'b0; doff = '0;
		mwe = 1'b0; midx = '0; mdata = mold;
		if (!in_data.action) begin
			acc_n = '0;
			if (pc_q != 3'd0) drop_n = 1'b1;
			if (choke_q) begin
				ph_n = PH_WAIT; ev = EV_INTERESTED;
			end else begin
				ph_n = (bneed == 11'd0) ? PH_DONE : PH_LOAD; ev = EV_INT_REQ;
			end
		end else if (pc_q < 3'd4) begin
			if (pc_q == 3'd0) drop_n = 1'b0;
			mlen_n = {mlen_q[23:0], b};
			pc_n = pc_q + 3'd1;
			if (pc_q == 3'd3 && mlen_n == 32'd0) begin
				ev = EV_KEEPALIVE; pc_n = 3'd0;
			end
		end else if (pc_q == 3'd4) begin
			kind_n = b; pos_n = '0; hdr_n = '0;
			pc_n = (plen == 32'd0) ? 3'd0 : 3'd5;
			if (drop_q || (ph_q != PH_WAIT && ph_q != PH_LOAD)) begin
				drop_n = 1'b1;
			end else begin
				unique case (b)
					KIND_CHOKE: begin
						choke_n = 1'b1; ph_n = PH_FAIL; ev = EV_CHOKED; drop_n = 1'b1;
					end
					KIND_UNCHOKE: begin
						if (ph_q == PH_WAIT) begin
							choke_n = 1'b0; ph_n = PH_LOAD; ev = EV_UNCHOKED;
						end
						drop_n = 1'b1;
					end
					KIND_HAVE: if (plen != HAVE_LEN) drop_n = 1'b1;
					KIND_BITFIELD: begin
						if (ph_q != PH_WAIT || plen != {21'd0, have_map_bytes}) drop_n = 1'b1;
						else if (plen == 32'd0) ev = EV_BITFIELD;
					end
					KIND_PIECE: begin
						if (ph_q != PH_LOAD) drop_n = 1'b1;
						else if (plen < PIECE_MIN) begin
							ev = EV_SHORT; ph_n = PH_FAIL; drop_n = 1'b1;
						end
					end
					default: drop_n = 1'b1;
				endcase
			end
		end else begin
			if (!drop_q) begin
				if (kind_q == KIND_HAVE) begin
					hdr_n = hdr_sh;
					if (last) begin
						if ({3'd0, hdr_sh} < hlim && hdr_sh < 32'(PIECE_SLOTS)) begin
							ev = EV_HAVE_SET; mwe = 1'b1;
							midx = MAW'(hdr_sh >> 3);
							mdata = 8'h80 >> hdr_sh[2:0];
						end else ev = EV_HAVE_RANGE;
					end
				end else if (kind_q == KIND_BITFIELD) begin
					if (pos_q < 32'(MAP_BYTES)) begin
						mwe = 1'b1; midx = MAW'(pos_q);
						mdata = b;
					end
					if (last) ev = EV_BITFIELD;
				end else if (kind_q == KIND_PIECE) begin
					if (pos_q < PIECE_HDR) begin
						hdr_n = hdr_sh;
						if (pos_q == 32'd3 && hdr_sh != piece_number) begin
							ev = EV_WRONG_PIECE; drop_n = 1'b1;
						end else if (pos_q == 32'd7 && ovs > {8'd0, piece_bytes}) begin
							ev = EV_OVERFLOW; ph_n = PH_FAIL; drop_n = 1'b1;
						end
					end else begin
						dv = 1'b1;
						doff = 24'(hdr_q + (pos_q - PIECE_HDR));
						if (last) begin
							acc_n = acc_q + 11'd1; ev = EV_BLOCK;
							if (acc_n >= bneed) begin
								ph_n = PH_DONE; ev = EV_COMPLETE;
							end
						end
					end
				end
			end
			pos_n = pos_q + 32'd1;
			if (pos_n >= plen) pc_n = 3'd0;
		end
	end

	// HAVE sets one bit; BITFIELD writes the byte except bits past PIECE_SLOTS.
	assign pbase = 32'({midx, 3'b000});
	always_comb begin
		for (int k = 0; k < 8; k++) pmask[7-k] = (pbase + 32'(k)) < 32'(PIECE_SLOTS);
		wmask = (kind_q == KIND_HAVE) ? mdata : pmask;
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			map_q[cidx_q] <= 8'd0;
		end else if (take && mwe) begin
			for (int k = 0; k < 8; k++) if (wmask[k]) map_q[midx][k] <= mdata[k];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.data_valid <= dv;
			out_q.data_offset <= doff;
			out_q.data_byte <= dv ? b : 8'd0;
			out_q.event_res <= ev;
			out_q.block_count <= bneed;
			out_q.blocks_done <= acc_n;
			out_q.phase <= ph_n;
			mlen_q <= mlen_n; kind_q <= kind_n; pos_q <= pos_n; hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0; drop_q <= 1'b0; ph_q <= PH_IDLE; choke_q <= 1'b1;
			acc_q <= '0; ov_q <= 1'b0; clr_q <= 1'b1; cidx_q <= '0;
		end else begin
			if (clr_q) begin
				cidx_q <= cidx_q + MAW'(1);
				if (cidx_q == MAW'(MAP_BYTES - 1)) clr_q <= 1'b0;
			end
			if (take) begin
				pc_q <= pc_n; drop_q <= drop_n; ph_q <= ph_n; choke_q <= choke_n;
				acc_q <= acc_n;
			end
			if (take) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign out_data = out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |-> !take) else $error("result overwritten");
	a_pc: assert property (@(posedge clk) disable iff (!arst_n) pc_q <= 3'd5)
		else $error("bad prefix count");
	a_dv: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dv) |-> ph_q == PH_LOAD) else $error("data outside download");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !take) else $error("word taken during map clear");
endmodule
`default_nettype wire

@@ sv/peer_wire_piece_receiver.sv @@
// Path: a word accepted on in_ch is written to the queue and later taken by the engine; its
// result is registered and held on out_ch until accepted. Throughput: one word per cycle
// unless the result stalls or the map is clearing; a 4-word queue lets intake run while the
// result stalls. Reset (arst_n low): queue empty, deframer at first length byte, phase idle,
// peer choking; the piece map is then cleared one byte per cycle ((PIECE_SLOTS+7)/8 bytes,
// 1024 by default), during which the queue takes up to 4 words and the engine takes none.
`default_nettype none
module peer_wire_piece_receiver
	import pwpr_pkg::*;
#(
	parameter int PIECE_SLOTS = 8192
) (
	input wire logic clk,
	input wire logic arst_n,
	pwpr_in_if.sink   in_ch,
	pwpr_out_if.source out_ch,
	pwpr_cfg_if.sink  cfg
);
	logic [31:0] pnum_q;
	logic [24:0] pbytes_q;
	logic [10:0] mbytes_q;
	in_word_t    qin, qout;
	logic        qv, qr;
	out_word_t   res;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnum_q <= '0; pbytes_q <= 25'd16384; mbytes_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PIECE_NUMBER: pnum_q <= cfg.data;
				CFG_PIECE_BYTES:  pbytes_q <= cfg.data[24:0];
				CFG_MAP_BYTES:    mbytes_q <= cfg.data[10:0];
				default: ;
			endcase
		end
	end

	assign qin.action = in_ch.action;
	assign qin.rx_byte = in_ch.rx_byte;

	pwpr_queue u_q (.clk, .arst_n, .wr_valid(in_ch.valid), .wr_ready(in_ch.ready),
		.wr_data(qin), .rd_valid(qv), .rd_ready(qr), .rd_data(qout));

	pwpr_engine #(.PIECE_SLOTS(PIECE_SLOTS)) u_eng (.clk, .arst_n, .in_valid(qv),
		.in_ready(qr), .in_data(qout), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(res), .piece_number(pnum_q), .piece_bytes(pbytes_q),
		.have_map_bytes(mbytes_q));

	assign out_ch.data_valid = res.data_valid;
	assign out_ch.data_offset = res.data_offset;
	assign out_ch.data_byte = res.data_byte;
	assign out_ch.event_res = res.event_res;
	assign out_ch.block_count = res.block_count;
	assign out_ch.blocks_done = res.blocks_done;
	assign out_ch.phase = res.phase;
endmodule
`default_nettype wire

@@ verif/tb_peer_wire_piece_receiver.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_peer_wire_piece_receiver;
	import pwpr_pkg::*;

	localparam int NPIECES = 8192;
	localparam int BLK_BYTES = 16384;
	localparam int MAXBLK = 1024;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pwpr_in_if in_ch();
	pwpr_out_if out_ch();
	pwpr_cfg_if cfg();

	peer_wire_piece_receiver dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register copies
	logic [31:0] want_piece;
	logic [24:0] piece_len;
	logic [10:0] map_len;

	// deframer / download tracking
	int unsigned pfx;
	logic [31:0] msg_len;
	logic [7:0]  msg_kind;
	logic [31:0] pay_pos;
	logic [63:0] hdr;
	bit          skip_msg;
	phase_t      dl_phase;
	bit          choked;
	logic [10:0] got_blocks;

	in_word_t    send_q[$];
	out_word_t   result_q[$];
	in_word_t    nxt;
	out_word_t   got;
	int unsigned send_idle, recv_stall;
	int unsigned words_in, words_out, data_words, errors, quiet;
	int unsigned ev_seen[16];

	function automatic logic [31:0] needed_blocks();
		logic [31:0] n;
		n = ({7'd0, piece_len} + BLK_BYTES - 1) / BLK_BYTES;
		return n > MAXBLK ? MAXBLK : n;
	endfunction

	function automatic out_word_t receive_word(logic act, logic [7:0] b);
		out_word_t r;
		logic [31:0] plen, idx;
		bit last;
		r = '0;
		r.event_res = EV_NONE;
		if (!act) begin
			got_blocks = '0;
			if (pfx != 0) skip_msg = 1;
			if (choked) begin
				dl_phase = PH_WAIT;
				r.event_res = EV_INTERESTED;
			end else begin
				dl_phase = needed_blocks() == 0 ? PH_DONE : PH_LOAD;
				r.event_res = EV_INT_REQ;
			end
		end else if (pfx < 4) begin
			if (pfx == 0) skip_msg = 0;
			msg_len = {msg_len[23:0], b};
			pfx++;
			if (pfx == 4 && msg_len == 0) begin
				r.event_res = EV_KEEPALIVE;
				pfx = 0;
			end
		end else if (pfx == 4) begin
			plen = msg_len - 1;
			msg_kind = b;
			pay_pos = 0;
			hdr = '0;
			pfx = plen == 0 ? 0 : 5;
			if (skip_msg || (dl_phase != PH_WAIT && dl_phase != PH_LOAD)) begin
				skip_msg = 1;
			end else begin
				case (msg_kind)
					KIND_CHOKE: begin
						choked = 1;
						dl_phase = PH_FAIL;
						r.event_res = EV_CHOKED;
						skip_msg = 1;
					end
					KIND_UNCHOKE: begin
						if (dl_phase == PH_WAIT) begin
							choked = 0;
							dl_phase = PH_LOAD;
							r.event_res = EV_UNCHOKED;
						end
						skip_msg = 1;
					end
					KIND_HAVE: if (plen != HAVE_LEN) skip_msg = 1;
					KIND_BITFIELD: begin
						if (dl_phase != PH_WAIT || plen != {21'd0, map_len}) skip_msg = 1;
						else if (plen == 0) r.event_res = EV_BITFIELD;
					end
					KIND_PIECE: begin
						if (dl_phase != PH_LOAD) begin
							skip_msg = 1;
						end else if (plen < PIECE_MIN) begin
							r.event_res = EV_SHORT;
							dl_phase = PH_FAIL;
							skip_msg = 1;
						end
					end
					default: skip_msg = 1;
				endcase
			end
		end else begin
			plen = msg_len - 1;
			last = (pay_pos + 1 == plen);
			if (!skip_msg) begin
				if (msg_kind == KIND_HAVE) begin
					hdr = {hdr[55:0], b};
					if (last) begin
						idx = hdr[31:0];
						if ({32'd0, idx} < {53'd0, map_len} * 8 && idx < NPIECES)
							r.event_res = EV_HAVE_SET;
						else
							r.event_res = EV_HAVE_RANGE;
					end
				end else if (msg_kind == KIND_BITFIELD) begin
					if (last) r.event_res = EV_BITFIELD;
				end else if (msg_kind == KIND_PIECE) begin
					if (pay_pos < PIECE_HDR) begin
						hdr = {hdr[55:0], b};
						if (pay_pos == 3 && hdr[31:0] != want_piece) begin
							r.event_res = EV_WRONG_PIECE;
							skip_msg = 1;
						end else if (pay_pos == 7 && {1'b0, hdr[31:0]} +
								{1'b0, plen - PIECE_HDR} > {8'd0, piece_len}) begin
							r.event_res = EV_OVERFLOW;
							dl_phase = PH_FAIL;
							skip_msg = 1;
						end
					end else begin
						idx = hdr[31:0] + pay_pos - PIECE_HDR;
						r.data_valid = 1;
						r.data_byte = b;
						r.data_offset = idx[23:0];
						if (last) begin
							got_blocks++;
							r.event_res = EV_BLOCK;
							if ({21'd0, got_blocks} >= needed_blocks()) begin
								dl_phase = PH_DONE;
								r.event_res = EV_COMPLETE;
							end
						end
					end
				end
			end
			pay_pos++;
			if (pay_pos >= plen) pfx = 0;
		end
		r.block_count = 11'(needed_blocks());
		r.blocks_done = got_blocks;
		r.phase = dl_phase;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= 1'b1;
			in_ch.rx_byte <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				result_q.push_back(receive_word(in_ch.action, in_ch.rx_byte));
				words_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					nxt = send_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.action <= nxt.action;
					in_ch.rx_byte <= nxt.rx_byte;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic cmp(string nm, int unsigned e, int unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, nm, e, a);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				words_out++;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected word, expected none got event %0d",
						$time, out_ch.event_res);
					errors++;
				end else begin
					got = result_q.pop_front();
					cmp("data_valid", got.data_valid, out_ch.data_valid);
					cmp("data_offset", got.data_offset, out_ch.data_offset);
					cmp("data_byte", got.data_byte, out_ch.data_byte);
					cmp("event_res", got.event_res, out_ch.event_res);
					cmp("block_count", got.block_count, out_ch.block_count);
					cmp("blocks_done", got.blocks_done, out_ch.blocks_done);
					cmp("phase", got.phase, out_ch.phase);
					ev_seen[got.event_res]++;
					if (got.data_valid) data_words++;
				end
			end
			out_ch.ready <= $urandom_range(99) >= recv_stall;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic put(bit act, logic [7:0] b);
		in_word_t w;
		w.action = act;
		w.rx_byte = b;
		send_q.push_back(w);
	endtask

	task automatic put32(logic [31:0] v);
		for (int i = 3; i >= 0; i--) put(1, v[i*8 +: 8]);
	endtask

	task automatic msg(logic [7:0] kind, logic [7:0] pl[$]);
		put32(pl.size() + 1);
		put(1, kind);
		foreach (pl[i]) put(1, pl[i]);
	endtask

	task automatic rand_bytes(ref logic [7:0] pl[$], input int n);
		repeat (n) pl.push_back(8'($urandom_range(255)));
	endtask

	task automatic piece_msg(logic [31:0] idx, logic [31:0] off, int n);
		logic [7:0] pl[$];
		for (int i = 3; i >= 0; i--) pl.push_back(idx[i*8 +: 8]);
		for (int i = 3; i >= 0; i--) pl.push_back(off[i*8 +: 8]);
		rand_bytes(pl, n);
		msg(KIND_PIECE, pl);
	endtask

	task automatic have_msg(logic [31:0] idx);
		logic [7:0] pl[$];
		for (int i = 3; i >= 0; i--) pl.push_back(idx[i*8 +: 8]);
		msg(KIND_HAVE, pl);
	endtask

	task automatic good_piece();
		int n;
		logic [31:0] off;
		n = $urandom_range(1, 12);
		if (n > piece_len) n = piece_len;
		off = $urandom_range(0, piece_len - n);
		case ($urandom_range(19))
			0: piece_msg($urandom, off, n);
			1: piece_msg(want_piece, piece_len - n + 1, n);
			2: piece_msg(want_piece, 32'hFFFF_FFFF, n);
			default: piece_msg(want_piece, off, n);
		endcase
	endtask

	task automatic session();
		logic [7:0] pl[$];
		int n;
		put(0, 8'($urandom_range(255)));
		if ($urandom_range(9) < 3) begin
			n = (map_len <= 16 || $urandom_range(9) == 0) ? map_len : 2;
			if ($urandom_range(4) == 0) n = $urandom_range(0, 6);
			rand_bytes(pl, n);
			msg(KIND_BITFIELD, pl);
			pl.delete();
		end
		repeat ($urandom_range(2)) have_msg($urandom_range(0, map_len * 8 + 2));
		if ($urandom_range(9) < 8) msg(KIND_UNCHOKE, pl);
		repeat ($urandom_range(1, 4)) begin
			pl.delete();
			case ($urandom_range(19))
				0: put32(0);
				1: begin
					rand_bytes(pl, $urandom_range(0, 5));
					msg(8'($urandom_range(255)), pl);
				end
				2: begin
					rand_bytes(pl, $urandom_range(0, 8));
					msg(KIND_PIECE, pl);
				end
				3: msg(KIND_CHOKE, pl);
				4: begin
					rand_bytes(pl, $urandom_range(0, 6));
					msg(KIND_HAVE, pl);
				end
				5: have_msg($urandom);
				6: begin
					put32(20);
					put(1, KIND_PIECE);
					put32(want_piece);
					put(0, 8'($urandom_range(255)));
					repeat (15) put(1, 8'($urandom_range(255)));
				end
				7: have_msg($urandom_range(0, map_len * 8 + 2));
				default: good_piece();
			endcase
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_PIECE_NUMBER: want_piece = v;
			CFG_PIECE_BYTES:  piece_len = v[24:0];
			CFG_MAP_BYTES:    map_len = v[10:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] nums[4];
		logic [31:0] lens[4];
		logic [31:0] maps[4];
		int unsigned idles[4];
		int unsigned stalls[4];
		logic [7:0] none[$];
		int target;
		nums = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd5};
		lens = '{32'd1, 32'd40, 32'd16777216, 32'd100};
		maps = '{32'd0, 32'd3, 32'd1024, 32'd1};
		idles = '{0, 84, 0, 36};
		stalls = '{0, 0, 84, 36};
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		send_idle = 0;
		recv_stall = 0;
		want_piece = '0;
		piece_len = 25'd16384;
		map_len = '0;
		pfx = 0;
		msg_len = '0;
		msg_kind = '0;
		pay_pos = '0;
		hdr = '0;
		skip_msg = 0;
		dl_phase = PH_IDLE;
		choked = 1;
		got_blocks = '0;
		words_in = 0;
		words_out = 0;
		data_words = 0;
		errors = 0;
		quiet = 0;
		foreach (ev_seen[i]) ev_seen[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		nums[2] = $urandom;
		target = 0;
		for (int p = 0; p < 4; p++) begin
			write_reg(CFG_PIECE_NUMBER, nums[p]);
			write_reg(CFG_PIECE_BYTES, lens[p]);
			write_reg(CFG_MAP_BYTES, maps[p]);
			send_idle = idles[p];
			recv_stall = stalls[p];
			if (p == 0) begin
				put32(0);
				put(0, 8'hFF);
				msg(KIND_UNCHOKE, none);
				piece_msg(32'd0, 32'd0, 1);
			end
			target += 310;
			while (words_in + send_q.size() < target) session();
			wait (send_q.size() == 0 && !in_ch.valid && result_q.size() == 0);
			repeat (8) @(posedge clk);
		end
		$display("%0d words sent, %0d results checked, %0d piece data words", words_in,
			words_out, data_words);
		$display("blocks %0d, completions %0d, haves %0d, errors flagged %0d",
			ev_seen[EV_BLOCK], ev_seen[EV_COMPLETE], ev_seen[EV_HAVE_SET],
			ev_seen[EV_WRONG_PIECE] + ev_seen[EV_CHOKED] + ev_seen[EV_SHORT]
			+ ev_seen[EV_OVERFLOW] + ev_seen[EV_HAVE_RANGE]);
		if (errors == 0 && result_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
